FILE: sv/sgtr_pkg.sv
// ----------------------------------------------------------------------------
// sgtr_pkg
// Shared types, constants and the 5x7 font table for the glyph rasterizer.
// ----------------------------------------------------------------------------
package sgtr_pkg;

  localparam int FONT_COLS = 5;
  localparam int FONT_ROWS = 7;
  localparam int COORD_W   = 12;
  localparam int CALC_W    = 14;
  localparam logic [3:0] SCALE_RESET = 4'd3;
  localparam logic signed [COORD_W:0] COORD_MAX = 13'sd2047;

  // column 0 at index 0, bit 0 is the top row
  typedef logic [0:FONT_COLS-1][FONT_ROWS-1:0] glyph_t;

  typedef struct packed {
    glyph_t              glyph;
    logic [COORD_W-1:0]  pen_x;
    logic [COORD_W-1:0]  text_y;
    logic [15:0]         color;
    logic [3:0]          scale;
  } job_t;

  typedef struct packed {
    logic [15:0] color;
    logic [3:0]  h;
    logic [3:0]  w;
    logic [7:0]  y;
    logic [8:0]  x;
  } rect_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FLUSH
  } back_state_t;

  function automatic glyph_t font_glyph(input logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (c inside {["a":"z"]}) c = c - 8'd32;
    case (c)
      " ": g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      ":": g = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      "-": g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
      ".": g = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
      "/": g = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
      "0": g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      "1": g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      "2": g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      "3": g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      "4": g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      "5": g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      "6": g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      "7": g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      "8": g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      "9": g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      "A": g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      "B": g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
      "C": g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      "D": g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      "E": g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      "F": g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      "G": g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
      "H": g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      "I": g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      "J": g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
      "K": g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      "L": g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      "M": g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      "N": g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
      "O": g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      "P": g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      "Q": g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
      "R": g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      "S": g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      "T": g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      "U": g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      "V": g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
      "W": g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
      "X": g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      "Y": g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      "Z": g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      default: g = {7'h02, 7'h01, 7'h59, 7'h09, 7'h06}; // question mark
    endcase
    return g;
  endfunction

endpackage

FILE: sv/sgtr_front.sv
// ----------------------------------------------------------------------------
// sgtr_front
// Accepts characters, looks up the glyph and keeps the text cursor.
// ----------------------------------------------------------------------------
module sgtr_front import sgtr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0]         scale,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_flag,
  input  logic [COORD_W-1:0] start_x,
  input  logic [COORD_W-1:0] text_y,
  input  logic [7:0]         char_code,
  input  logic [15:0]        text_color,
  output logic               push_valid,
  input  logic               push_ready,
  output job_t               push_job
);

  logic [COORD_W-1:0]        cursor_r;
  logic [COORD_W-1:0]        cursor_nxt;
  logic [COORD_W-1:0]        cur_use;
  logic [6:0]                adv;
  logic signed [COORD_W:0]   sum;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    cur_use = start_flag ? start_x : cursor_r;
    adv     = 7'((FONT_COLS + 1) * scale);
    sum     = $signed({cur_use[COORD_W-1], cur_use}) + $signed({6'b0, adv});
    if (sum > COORD_MAX) begin
      cursor_nxt = COORD_MAX[COORD_W-1:0];
    end else begin
      cursor_nxt = sum[COORD_W-1:0];
    end
    push_job.glyph  = font_glyph(char_code);
    push_job.pen_x  = cur_use;
    push_job.text_y = text_y;
    push_job.color  = text_color;
    push_job.scale  = scale;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (in_valid && push_ready) begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

FILE: sv/sgtr_fifo.sv
// ----------------------------------------------------------------------------
// sgtr_fifo
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module sgtr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNTW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: sv/sgtr_back.sv
// ----------------------------------------------------------------------------
// sgtr_back
// Walks a dot per cycle unless output stalls; clips each square to the panel.
// One square is held back so the final one can carry the last flag.
// ----------------------------------------------------------------------------
module sgtr_back import sgtr_pkg::*; #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 240
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  job_valid,
  output logic  job_ready,
  input  job_t  job,
  output logic  out_valid,
  input  logic  out_ready,
  output rect_t out_rect,
  output logic  out_last
);

  localparam logic signed [CALC_W-1:0] PW = CALC_W'(PANEL_WIDTH);
  localparam logic signed [CALC_W-1:0] PH = CALC_W'(PANEL_HEIGHT);
  localparam logic [2:0] LAST_COL = 3'(FONT_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(FONT_ROWS - 1);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [2:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;
  rect_t       pend_r;
  logic        pend_v_r, pend_v_nxt;
  rect_t       out_rect_r;
  logic        out_last_r;
  logic        out_v_r, out_v_nxt;

  logic [6:0]               col_off, row_off;
  logic signed [CALC_W-1:0] s_ext, x0, y0, xc, yc, w1, h1, w2, h2;
  logic                     cand_vis, out_free, adv, load_job, out_load, out_load_last;
  rect_t                    cand;

  assign out_valid = out_v_r;
  assign out_rect  = out_rect_r;
  assign out_last  = out_last_r;
  assign out_free  = !out_v_r || out_ready;
  assign job_ready = (state_r == BK_IDLE);
  assign load_job  = job_ready && job_valid;

  always_comb begin
    col_off = 7'(col_r) * 7'(job_r.scale);
    row_off = 7'(row_r) * 7'(job_r.scale);
    s_ext   = {{(CALC_W-4){1'b0}}, job_r.scale};
    x0 = {{(CALC_W-COORD_W){job_r.pen_x[COORD_W-1]}}, job_r.pen_x}
       + {{(CALC_W-7){1'b0}}, col_off};
    y0 = {{(CALC_W-COORD_W){job_r.text_y[COORD_W-1]}}, job_r.text_y}
       + {{(CALC_W-7){1'b0}}, row_off};
    if (x0 < 0) begin
      xc = '0;
      w1 = s_ext + x0;
    end else begin
      xc = x0;
      w1 = s_ext;
    end
    if (y0 < 0) begin
      yc = '0;
      h1 = s_ext + y0;
    end else begin
      yc = y0;
      h1 = s_ext;
    end
    w2 = (xc + w1 > PW) ? PW - xc : w1;
    h2 = (yc + h1 > PH) ? PH - yc : h1;
    cand_vis = job_r.glyph[col_r][row_r] && (xc < PW) && (yc < PH)
             && (w2 > 0) && (h2 > 0);
    cand.x     = xc[8:0];
    cand.y     = yc[7:0];
    cand.w     = w2[3:0];
    cand.h     = h2[3:0];
    cand.color = job_r.color;
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pend_v_nxt    = pend_v_r;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    adv           = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = BK_WALK;
          col_nxt   = '0;
          row_nxt   = '0;
        end
      end
      BK_WALK: begin
        adv = !cand_vis || !pend_v_r || out_free;
        if (adv) begin
          if (cand_vis) begin
            pend_v_nxt = 1'b1;
            out_load   = pend_v_r;
          end
          if (row_r == LAST_ROW) begin
            row_nxt = '0;
            if (col_r == LAST_COL) begin
              state_nxt = BK_FLUSH;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      BK_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = BK_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      job_r <= job;
    end
    if (out_load) begin
      out_rect_r <= pend_r;
      out_last_r <= out_load_last;
    end
    if (adv && cand_vis) begin
      pend_r <= cand;
    end
  end

endmodule

FILE: sv/scaled_glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// scaled_glyph_text_rasterizer
// Turns characters into clipped, scaled 5x7 font squares for a panel.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tuser start_flag, tdata char fields
//   out_    | out | out_tvalid/out_tready| tdata square fields, tlast last_rect
//   cfg_    | in  | APB, pready = 1      | reg 0 glyph_scale at byte addr 0
//
// The back end loads a character from the queue, walks its glyph dots one
// per cycle unless the output stalls, and then flushes the held square.
// The front end takes a character per cycle while the queue has room.
// Output stalls hold the dot walk; input stalls leave the back end running.
// Reset clears the cursor and queue and sets glyph_scale to 3.
// ----------------------------------------------------------------------------
module scaled_glyph_text_rasterizer import sgtr_pkg::*; #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 240,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] start_x, [23:12] text_y, [31:24] char_code, [47:32] text_color
  input  logic [47:0] in_tdata,
  // [0] start_flag
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [8:0] rect_x, [16:9] rect_y, [20:17] rect_w, [24:21] rect_h,
  // [40:25] fill_color, [47:41] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0] scale_r;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  job_t       push_job, pop_job;
  rect_t      rect;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {28'd0, scale_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      scale_r <= cfg_pwdata[3:0];
    end
  end

  sgtr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .scale      (scale_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .start_flag (in_tuser),
    .start_x    (in_tdata[11:0]),
    .text_y     (in_tdata[23:12]),
    .char_code  (in_tdata[31:24]),
    .text_color (in_tdata[47:32]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sgtr_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  sgtr_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rect  (rect),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, rect};

endmodule

FILE: tb/sv/tb_scaled_glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_scaled_glyph_text_rasterizer
// Drives characters into the glyph rasterizer and checks every emitted square.
// A behavioral font walker predicts the clipped squares and the text cursor
// per accepted character; output beats are compared in order, field by field.
// Covers glyph_scale settings from 0 to 15, panel clipping on all edges,
// cursor saturation, case folding, unknown codes, and random strings under
// random stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_scaled_glyph_text_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W     = 320;
  localparam int PANEL_H     = 240;
  localparam int CURSOR_MAX  = 2047;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 160;
  localparam logic [2:0] ADDR_GLYPH_SCALE = 3'd0;
  localparam string TEXT_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  localparam string PUNCT_CHARS = " :-./?";

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [15:0] color;
    logic        last_rect;
  } square_t;

  // one entry per glyph slot, column 0 in the top byte, bit 0 = top row
  logic [39:0] glyph_rom [42] = '{
    40'h0000000000, 40'h0201590906, 40'h0036360000, 40'h0808080808,
    40'h0060600000, 40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10, 40'h2745454539,
    40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // [11:0] start_x, [23:12] text_y, [31:24] char_code, [47:32] text_color
  logic [47:0] in_tdata = '0;
  // [0] start_flag
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [8:0] rect_x, [16:9] rect_y, [20:17] rect_w, [24:21] rect_h,
  // [40:25] fill_color, [47:41] zero
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  square_t     pending_squares [$];
  int          cursor_pos = 0;
  logic [3:0]  scale_now = sgtr_pkg::SCALE_RESET;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          tx_jitter = 1'b1;
  bit          rx_jitter = 1'b1;
  int          rx_hold = 0;
  int          rx_idle = 0;

  scaled_glyph_text_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  function automatic int glyph_slot(logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "0" && c <= "9") return 6 + int'(c - "0");
    if (c >= "A" && c <= "Z") return 16 + int'(c - "A");
    case (c)
      " ":     return 0;
      ":":     return 2;
      "-":     return 3;
      ".":     return 4;
      "/":     return 5;
      default: return 1;
    endcase
  endfunction

  // walks the glyph, queues the visible squares and moves the cursor
  function automatic void predict_glyph_squares(bit flag, logic signed [11:0] sx,
                                                logic signed [11:0] ty,
                                                logic [7:0] code, logic [15:0] color);
    int      s, x, y, w, h, slot;
    square_t sq, held;
    bit      have_held;
    s = int'(scale_now);
    slot = glyph_slot(code);
    have_held = 1'b0;
    if (flag) cursor_pos = sx;
    if (s > 0) begin
      for (int col = 0; col < 5; col++) begin
        for (int row = 0; row < 7; row++) begin
          if (!glyph_rom[slot][(4 - col) * 8 + row]) continue;
          x = cursor_pos + col * s;
          y = int'(ty) + row * s;
          w = s;
          h = s;
          if (x < 0) begin
            w += x;
            x = 0;
          end
          if (y < 0) begin
            h += y;
            y = 0;
          end
          if (x >= PANEL_W || y >= PANEL_H) continue;
          if (x + w > PANEL_W) w = PANEL_W - x;
          if (y + h > PANEL_H) h = PANEL_H - y;
          if (w <= 0 || h <= 0) continue;
          sq.x = x[8:0];
          sq.y = y[7:0];
          sq.w = w[3:0];
          sq.h = h[3:0];
          sq.color = color;
          sq.last_rect = 1'b0;
          if (have_held) pending_squares.push_back(held);
          held = sq;
          have_held = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last_rect = 1'b1;
      pending_squares.push_back(held);
    end
    cursor_pos += 6 * s;
    if (cursor_pos > CURSOR_MAX) cursor_pos = CURSOR_MAX;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_char(bit flag, logic [11:0] sx, logic [11:0] ty,
                           logic [7:0] code, logic [15:0] color);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= flag;
    in_tdata  <= {color, code, ty, sx};
    do @(posedge clk); while (!in_tready);
    predict_glyph_squares(flag, sx, ty, code, color);
    gap = 0;
    if (tx_jitter && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // called after the last send_char; drops tvalid unless a gap already did
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_scale(logic [3:0] value);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[3:0] = value;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_GLYPH_SCALE;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    scale_now = value;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("glyph_scale readback", {12'd0, scale_now}, {12'd0, cfg_prdata[3:0]});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [11:0] pick_coord(int lo, int hi);
    int v;
    if ($urandom_range(0, 99) < 80) v = $urandom_range(0, hi - lo) + lo;
    else v = $urandom_range(0, 4095);
    return v[11:0];
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return TEXT_CHARS[$urandom_range(0, TEXT_CHARS.len() - 1)];
    if (r < 72) return PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed_glyphs();
    send_char(1'b0, 12'h800, 12'd0, "0", 16'hFFFF);
    send_char(1'b1, 12'd10, 12'd20, "H", 16'h0000);
    send_char(1'b0, 12'h7FF, 12'd20, "e", 16'hF800);
    send_char(1'b0, 12'd0, 12'd20, " ", 16'h07E0);
    send_char(1'b0, 12'd0, 12'd20, ":", 16'h001F);
    send_char(1'b0, 12'd0, 12'd20, "-", 16'hAAAA);
    send_char(1'b0, 12'd0, 12'd20, ".", 16'h5555);
    send_char(1'b0, 12'd0, 12'd20, "/", 16'h1234);
    send_char(1'b0, 12'd0, 12'd20, "?", 16'hFEDC);
    send_char(1'b0, 12'd0, 12'd20, 8'h00, 16'h0F0F);
    send_char(1'b0, 12'd0, 12'd20, 8'hFF, 16'hF0F0);
    send_char(1'b0, 12'd0, 12'd20, 8'h80, 16'h8001);
    send_char(1'b0, 12'd0, 12'd20, "z", 16'h7FFE);
    send_char(1'b0, 12'd0, 12'd20, "9", 16'hFFFF);
    send_char(1'b1, 12'(-5), 12'(-4), "M", 16'h4321);
    send_char(1'b1, 12'd316, 12'd236, "8", 16'h8765);
    send_char(1'b1, 12'h800, 12'h800, "W", 16'h0001);
    send_char(1'b1, 12'd2040, 12'h7FF, "B", 16'h8000);
    send_char(1'b0, 12'd0, 12'd100, "X", 16'hCAFE);
    send_char(1'b1, 12'd300, 12'd230, "#", 16'h0BAD);
    drain();
  endtask

  task automatic test_scale_extremes();
    write_scale(4'd0);
    send_char(1'b1, 12'd100, 12'd100, "8", 16'h1111);
    send_char(1'b0, 12'd0, 12'd100, "A", 16'h2222);
    drain();
    write_scale(4'd15);
    send_char(1'b0, 12'd0, 12'd100, "B", 16'h3333);
    send_char(1'b1, 12'd290, 12'd190, "W", 16'h4444);
    send_char(1'b1, 12'(-40), 12'(-50), "8", 16'h5555);
    drain();
  endtask

  task automatic test_random_text(logic [3:0] scale, bit jitter, int count);
    logic [11:0] sx, ty;
    bit          flag;
    tx_jitter = jitter;
    rx_jitter = jitter;
    write_scale(scale);
    ty = pick_coord(-60, 260);
    for (int i = 0; i < count; i++) begin
      flag = (i == 0) || ($urandom_range(0, 99) < 20);
      sx = flag ? pick_coord(-60, 340) : 12'($urandom_range(0, 4095));
      if (flag) ty = pick_coord(-60, 260);
      send_char(flag, sx, ty, pick_code(), 16'($urandom_range(0, 65535)));
    end
    drain();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  task automatic test_output_holdoff();
    tx_jitter = 1'b0;
    write_scale(4'd8);
    rx_hold = 500;
    send_char(1'b1, 12'd4, 12'd8, "8", 16'hA5A5);
    for (int i = 0; i < 11; i++)
      send_char(1'b0, 12'd0, 12'd8, TEXT_CHARS[$urandom_range(0, 35)],
                16'($urandom_range(0, 65535)));
    drain();
    tx_jitter = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_glyphs();
    test_scale_extremes();
    test_random_text(4'd1, 1'b1, 25);
    test_random_text(4'd8, 1'b0, 20);
    test_random_text(4'($urandom_range(2, 7)), 1'b1, 20);
    test_random_text(4'($urandom_range(0, 15)), 1'b1, 20);
    test_output_holdoff();
    if (mismatches == 0) begin
      $display("scaled_glyph_text_rasterizer: match");
    end else begin
      $display("scaled_glyph_text_rasterizer: mismatch");
    end
    $finish;
  end

  // output side: long hold-off first, then random short/long stalls
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_idle > 0) begin
        out_tready <= 1'b0;
        rx_idle--;
      end else begin
        out_tready <= 1'b1;
        if (rx_jitter && $urandom_range(0, 99) < 15) rx_idle = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_beat
    square_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_squares.size() == 0) begin
        $error("unexpected square beat: x=%0d y=%0d", out_tdata[8:0], out_tdata[16:9]);
        mismatches++;
      end else begin
        want = pending_squares.pop_front();
        check_field("rect_x", {7'd0, want.x}, {7'd0, out_tdata[8:0]});
        check_field("rect_y", {8'd0, want.y}, {8'd0, out_tdata[16:9]});
        check_field("rect_w", {12'd0, want.w}, {12'd0, out_tdata[20:17]});
        check_field("rect_h", {12'd0, want.h}, {12'd0, out_tdata[24:21]});
        check_field("fill_color", want.color, out_tdata[40:25]);
        check_field("pad", 16'd0, {9'd0, out_tdata[47:41]});
        check_field("last_rect", {15'd0, want.last_rect}, {15'd0, out_tlast});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("scaled_glyph_text_rasterizer: mismatch");
    $finish;
  end

endmodule

FILE: files.f
sv/sgtr_pkg.sv
sv/sgtr_front.sv
sv/sgtr_fifo.sv
sv/sgtr_back.sv
sv/scaled_glyph_text_rasterizer.sv
tb/sv/tb_scaled_glyph_text_rasterizer.sv
